// ----- rtl/lz4d_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package lz4d_pkg;

  localparam int unsigned SizeW       = 25;
  localparam int unsigned WinAw       = 16;
  localparam int unsigned WindowDepth = 65536;
  localparam int unsigned ChunkW      = 6;
  localparam int unsigned ChunkDef    = 32;
  localparam int unsigned MaxBlockDef = 16777216;

  localparam logic [1:0] ModeByte = 2'd0;
  localparam logic [1:0] ModeEnd  = 2'd1;
  localparam logic [1:0] ModePull = 2'd2;
  localparam logic [1:0] ModeRsvd = 2'd3;

  localparam logic KindData   = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef enum logic [1:0] {
    CK_NONE,
    CK_LIT,
    CK_CHUNK
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e              kind;
    logic [7:0]             lit;
    logic [ChunkW-1:0]      cnt;
    logic [WinAw-1:0]       mdist;
    logic                   pending;
    logic                   refused;
    logic                   stat;
    logic                   success;
    logic [SizeW-1:0]       count;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/lz4_block_partial_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// LZ4 block decoder, one compressed byte per input beat.
// Write the exact decoded size on the cfg channel (cfg_valid_i/cfg_ready_o,
// always ready) while the block is idle; values above MAX_BLOCK saturate.
// Slave stream: tuser = mode (byte, end of empty source, pull), tdata = byte,
// tlast = final compressed byte. Master stream: tuser = kind (data/status),
// tlast = last beat caused by that input beat.
// A front parser takes one beat per cycle while the queue has room and posts at
// most one command per beat into a four-entry queue; the back end takes each
// command, then writes the 64 KiB history and drives the output register. A
// literal beat is written and output directly; each match byte takes a
// registered history read, then a write and output. A match beat yields at most
// CHUNK_BYTES bytes; send pull beats while match_pending is set.
// When the receiver stalls the output register holds and the queue fills,
// then tready drops. Reset clears control state; the history is not cleared,
// and the block ignores every beat after its status until the next reset.
module lz4_block_partial_decoder #(
  parameter int unsigned CHUNK_BYTES = lz4d_pkg::ChunkDef,
  parameter int unsigned MAX_BLOCK   = lz4d_pkg::MaxBlockDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire logic [lz4d_pkg::SizeW-1:0] cfg_data_i,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [7:0]                 s_axis_tdata,  // [7:0] data_byte
  input  wire logic [1:0]                 s_axis_tuser,  // [1:0] mode
  input  wire logic                       s_axis_tlast,
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // [7:0] out_byte, [8] match_pending, [9] refused, [10] success,
  // [35:11] good_count, [39:36] zero
  output logic [39:0]                     m_axis_tdata,
  output logic                            m_axis_tuser,  // [0] kind
  output logic                            m_axis_tlast
);
  import lz4d_pkg::*;

  cmd_t             fcmd, bcmd;
  logic             fpush, full, empty, pop;
  logic             in_fire;
  logic [7:0]       obyte;
  logic             opend, oref, osucc;
  logic [SizeW-1:0] ocnt;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !full;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tdata  = {4'b0, ocnt, osucc, oref, opend, obyte};

  lz4d_front #(.CHUNK_BYTES(CHUNK_BYTES), .MAX_BLOCK(MAX_BLOCK)) u_front (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_data_i,
    .in_fire_i(in_fire), .mode_i(s_axis_tuser), .byte_i(s_axis_tdata),
    .last_i(s_axis_tlast), .cmd_o(fcmd), .push_o(fpush)
  );

  lz4d_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(fpush), .wdata_i(fcmd), .full_o(full),
    .pop_i(pop), .empty_o(empty), .rdata_o(bcmd)
  );

  lz4d_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .cmd_i(bcmd), .pop_o(pop),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready),
    .m_kind_o(m_axis_tuser), .m_last_o(m_axis_tlast), .m_byte_o(obyte),
    .m_pending_o(opend), .m_refused_o(oref), .m_success_o(osucc), .m_count_o(ocnt)
  );

endmodule
`default_nettype wire

// ----- rtl/lz4d_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lz4d_front #(
  parameter int unsigned CHUNK_BYTES = lz4d_pkg::ChunkDef,
  parameter int unsigned MAX_BLOCK   = lz4d_pkg::MaxBlockDef
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_valid_i,
  input  wire logic [lz4d_pkg::SizeW-1:0] cfg_data_i,
  input  wire logic                       in_fire_i,
  input  wire logic [1:0]                 mode_i,
  input  wire logic [7:0]                 byte_i,
  input  wire logic                       last_i,
  output lz4d_pkg::cmd_t                  cmd_o,
  output logic                            push_o
);
  import lz4d_pkg::*;

  localparam logic [2:0] PhToken   = 3'd0;
  localparam logic [2:0] PhLitExt  = 3'd1;
  localparam logic [2:0] PhLiteral = 3'd2;
  localparam logic [2:0] PhOffLo   = 3'd3;
  localparam logic [2:0] PhOffHi   = 3'd4;
  localparam logic [2:0] PhMatExt  = 3'd5;
  localparam logic [2:0] PhMatch   = 3'd6;
  localparam logic [2:0] PhMatEnd  = 3'd7;

  localparam logic [SizeW-1:0]  MaxBlk = SizeW'(MAX_BLOCK);
  localparam logic [SizeW-1:0]  Sat    = '1;
  localparam logic [ChunkW-1:0] Chunk  = ChunkW'(CHUNK_BYTES);

  logic [2:0]       ph_q, ph_d;
  logic [3:0]       nib_q, nib_d;
  logic [SizeW-1:0] acc_q, acc_d, rem_q, rem_d, wc_q, wc_d, gm_q, gm_d, exp_q;
  logic [7:0]       offl_q, offl_d;
  logic [WinAw-1:0] dist_q, dist_d;
  logic             fin_q, fin_d;

  function automatic logic [SizeW-1:0] sat_add(logic [SizeW-1:0] a, logic [SizeW-1:0] b);
    logic [SizeW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SizeW] ? Sat : s[SizeW-1:0];
  endfunction

  always_comb begin
    logic             drain, start, sended, refd, draining;
    logic [SizeW-1:0] slen;
    logic [ChunkW-1:0] n;
    ph_d = ph_q; nib_d = nib_q; acc_d = acc_q; offl_d = offl_q; dist_d = dist_q;
    rem_d = rem_q; wc_d = wc_q; gm_d = gm_q; fin_d = fin_q;
    cmd_o = '0;
    drain = 1'b0; start = 1'b0; sended = 1'b0; refd = 1'b0; slen = '0; n = '0;
    draining = (ph_q == PhMatch) || (ph_q == PhMatEnd);
    if (in_fire_i && !fin_q && (mode_i != ModeRsvd)) begin
      if (mode_i == ModePull) begin
        drain = draining;
      end else if (draining) begin
        refd  = 1'b1;
        drain = 1'b1;
      end else if (exp_q == '0) begin
        cmd_o.stat = 1'b1; cmd_o.success = 1'b1; cmd_o.count = exp_q; fin_d = 1'b1;
      end else if (mode_i == ModeEnd) begin
        cmd_o.stat = 1'b1; fin_d = 1'b1;
        cmd_o.success = (ph_q == PhToken) && (wc_q == '0);
        cmd_o.count   = cmd_o.success ? '0 : gm_q;
      end else begin
        case (ph_q)
          PhToken, PhLitExt: begin
            if (ph_q == PhToken) begin
              nib_d = byte_i[3:0];
              acc_d = SizeW'(byte_i[7:4]);
            end else begin
              acc_d = sat_add(acc_q, SizeW'(byte_i));
            end
            if ((ph_q == PhToken && byte_i[7:4] == 4'hF) ||
                (ph_q == PhLitExt && byte_i == 8'hFF) ||
                (ph_q == PhLitExt && last_i)) begin
              if (last_i) begin
                cmd_o.stat = 1'b1; cmd_o.count = gm_q; fin_d = 1'b1;
              end else begin
                ph_d = PhLitExt;
              end
            end else if (({1'b0, wc_q} + {1'b0, acc_d}) > {1'b0, exp_q}) begin
              cmd_o.stat = 1'b1; cmd_o.count = gm_q; fin_d = 1'b1;
            end else if (acc_d == '0) begin
              if (wc_q == exp_q) begin
                cmd_o.stat = 1'b1; cmd_o.success = 1'b1; cmd_o.count = exp_q; fin_d = 1'b1;
              end else if (last_i) begin
                cmd_o.stat = 1'b1; cmd_o.count = gm_q; fin_d = 1'b1;
              end else begin
                ph_d = PhOffLo;
              end
            end else if (last_i) begin
              cmd_o.stat = 1'b1; cmd_o.count = gm_q; fin_d = 1'b1;
            end else begin
              ph_d = PhLiteral;
            end
          end
          PhLiteral: begin
            cmd_o.kind = CK_LIT;
            cmd_o.lit  = byte_i;
            wc_d  = wc_q + 1'b1;
            acc_d = acc_q - 1'b1;
            if (acc_d == '0) begin
              if (wc_d == exp_q) begin
                cmd_o.stat = 1'b1; cmd_o.success = 1'b1; cmd_o.count = exp_q; fin_d = 1'b1;
              end else if (last_i) begin
                cmd_o.stat = 1'b1; cmd_o.count = gm_q; fin_d = 1'b1;
              end else begin
                ph_d = PhOffLo;
              end
            end else if (last_i) begin
              cmd_o.stat = 1'b1; cmd_o.count = gm_q; fin_d = 1'b1;
            end
          end
          PhOffLo: begin
            offl_d = byte_i;
            if (last_i) begin
              cmd_o.stat = 1'b1; cmd_o.count = gm_q; fin_d = 1'b1;
            end else begin
              ph_d = PhOffHi;
            end
          end
          PhOffHi: begin
            dist_d = {byte_i, offl_q};
            if (dist_d == '0 || SizeW'(dist_d) > wc_q) begin
              cmd_o.stat = 1'b1; cmd_o.count = gm_q; fin_d = 1'b1;
            end else if (nib_q == 4'hF) begin
              if (last_i) begin
                cmd_o.stat = 1'b1; cmd_o.count = gm_q; fin_d = 1'b1;
              end else begin
                acc_d = SizeW'(4'hF);
                ph_d  = PhMatExt;
              end
            end else begin
              start  = 1'b1;
              slen   = SizeW'(nib_q) + SizeW'(4);
              sended = last_i;
            end
          end
          PhMatExt: begin
            acc_d = sat_add(acc_q, SizeW'(byte_i));
            if (byte_i != 8'hFF || last_i) begin
              start  = 1'b1;
              slen   = sat_add(acc_d, SizeW'(4));
              sended = last_i;
            end
          end
          default: ;
        endcase
        if (start) begin
          if (({1'b0, wc_q} + {1'b0, slen}) > {1'b0, exp_q}) begin
            cmd_o.stat = 1'b1; cmd_o.count = gm_q; fin_d = 1'b1;
          end else begin
            rem_d = slen;
            ph_d  = sended ? PhMatEnd : PhMatch;
            drain = 1'b1;
          end
        end
      end
      if (drain) begin
        n = (rem_d < SizeW'(Chunk)) ? rem_d[ChunkW-1:0] : Chunk;
        cmd_o.kind  = CK_CHUNK;
        cmd_o.cnt   = n;
        cmd_o.mdist = dist_d;
        rem_d = rem_d - SizeW'(n);
        wc_d  = wc_d + SizeW'(n);
        if (rem_d == '0) begin
          gm_d = wc_d;
          if (ph_d == PhMatEnd) begin
            cmd_o.stat = 1'b1; cmd_o.count = gm_d; fin_d = 1'b1;
          end else begin
            ph_d = PhToken;
          end
        end
      end
      cmd_o.pending = (rem_d != '0);
      cmd_o.refused = refd;
    end
    push_o = (cmd_o.kind != CK_NONE) || cmd_o.stat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PhToken; nib_q <= '0; acc_q <= '0; offl_q <= '0; dist_q <= '0;
      rem_q <= '0; wc_q <= '0; gm_q <= '0; fin_q <= 1'b0; exp_q <= '0;
    end else begin
      ph_q <= ph_d; nib_q <= nib_d; acc_q <= acc_d; offl_q <= offl_d; dist_q <= dist_d;
      rem_q <= rem_d; wc_q <= wc_d; gm_q <= gm_d; fin_q <= fin_d;
      if (cfg_valid_i) begin
        exp_q <= (cfg_data_i > MaxBlk) ? MaxBlk : cfg_data_i;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/lz4d_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lz4d_fifo (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire lz4d_pkg::cmd_t wdata_i,
  output logic       full_o,
  input  wire logic  pop_i,
  output logic       empty_o,
  output lz4d_pkg::cmd_t rdata_o
);
  import lz4d_pkg::*;

  cmd_t       mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  assign full_o  = (cnt_q == 3'd4);
  assign empty_o = (cnt_q == 3'd0);
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + 3'(push_i) - 3'(pop_i);
    end
  end

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("command queue overrun");

endmodule
`default_nettype wire

// ----- rtl/lz4d_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module lz4d_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       empty_i,
  input  wire lz4d_pkg::cmd_t             cmd_i,
  output logic                            pop_o,
  output logic                            m_valid_o,
  input  wire logic                       m_ready_i,
  output logic                            m_kind_o,
  output logic                            m_last_o,
  output logic [7:0]                      m_byte_o,
  output logic                            m_pending_o,
  output logic                            m_refused_o,
  output logic                            m_success_o,
  output logic [lz4d_pkg::SizeW-1:0]      m_count_o
);
  import lz4d_pkg::*;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SLit  = 3'd1;
  localparam logic [2:0] SRd   = 3'd2;
  localparam logic [2:0] SWr   = 3'd3;
  localparam logic [2:0] SStat = 3'd4;

  logic [7:0]        hist_q [WindowDepth];
  logic [7:0]        rdata_q;
  logic [2:0]        st_q;
  cmd_t              cmd_q;
  logic [ChunkW-1:0] cnt_q;
  logic [WinAw-1:0]  wp_q;
  logic              free, wr_en, emit;
  logic [7:0]        wr_data;
  logic [WinAw-1:0]  raddr;

  assign free    = !m_valid_o || m_ready_i;
  assign pop_o   = (st_q == SIdle) && !empty_i;
  assign raddr   = wp_q - cmd_q.mdist;
  assign wr_en   = free && ((st_q == SLit) || (st_q == SWr));
  assign emit    = free && ((st_q == SLit) || (st_q == SWr) || (st_q == SStat));
  assign wr_data = (st_q == SLit) ? cmd_q.lit : rdata_q;

  always_ff @(posedge clk_i) begin
    rdata_q <= hist_q[raddr];
    if (wr_en) begin
      hist_q[wp_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= SIdle;
      m_valid_o <= 1'b0;
      wp_q      <= '0;
    end else begin
      if (m_ready_i && !emit) m_valid_o <= 1'b0;
      case (st_q)
        SIdle: begin
          if (!empty_i) begin
            cmd_q <= cmd_i;
            cnt_q <= cmd_i.cnt;
            case (cmd_i.kind)
              CK_LIT:   st_q <= SLit;
              CK_CHUNK: st_q <= SRd;
              default:  st_q <= SStat;
            endcase
          end
        end
        SRd: st_q <= SWr;
        SLit, SWr: begin
          if (free) begin
            m_valid_o   <= 1'b1;
            m_kind_o    <= KindData;
            m_byte_o    <= wr_data;
            m_pending_o <= cmd_q.pending;
            m_refused_o <= cmd_q.refused;
            m_success_o <= 1'b0;
            m_count_o   <= '0;
            wp_q        <= wp_q + 1'b1;
            cnt_q       <= cnt_q - 1'b1;
            if (st_q == SWr && cnt_q != ChunkW'(1)) begin
              m_last_o <= 1'b0;
              st_q     <= SRd;
            end else begin
              m_last_o <= !cmd_q.stat;
              st_q     <= cmd_q.stat ? SStat : SIdle;
            end
          end
        end
        SStat: begin
          if (free) begin
            m_valid_o   <= 1'b1;
            m_kind_o    <= KindStatus;
            m_byte_o    <= '0;
            m_pending_o <= 1'b0;
            m_refused_o <= cmd_q.refused;
            m_success_o <= cmd_q.success;
            m_count_o   <= cmd_q.count;
            m_last_o    <= 1'b1;
            st_q        <= SIdle;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end

  a_wr_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == SWr) |-> (cnt_q != '0)) else $error("match copy with no bytes left");
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_o && m_kind_o == KindStatus) |-> m_last_o) else $error("status not last");
  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_o && m_kind_o == KindData) |-> (!m_success_o && m_count_o == '0))
    else $error("data beat carries status fields");

endmodule
`default_nettype wire

// ----- tb/lz4_scoreboard.sv -----
`timescale 1ns / 1ps
module lz4_scoreboard
  import lz4d_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_i,
  input  logic [SizeW-1:0] cfg_data_i,
  input  logic             s_tvalid_i,
  input  logic             s_tready_i,
  input  logic [7:0]       s_tdata_i,
  input  logic [1:0]       s_tuser_i,
  input  logic             s_tlast_i,
  input  logic             m_tvalid_i,
  input  logic             m_tready_i,
  input  logic [39:0]      m_tdata_i,
  input  logic             m_tuser_i,
  input  logic             m_tlast_i,
  output int               errors_o,
  output int               waiting_o,
  output int               data_beats_o
);

  typedef enum logic [2:0] {
    PhToken, PhLitExt, PhLiteral, PhOffLo, PhOffHi, PhMatchExt, PhMatch, PhMatchEnd
  } phase_e;

  typedef struct packed {
    logic             kind;
    logic [7:0]       dbyte;
    logic             pend;
    logic             refused;
    logic             success;
    logic [SizeW-1:0] count;
    logic             last;
  } beat_t;

  localparam logic [SizeW-1:0] SatVal = '1;

  logic [7:0]       hist [WindowDepth];
  phase_e           ph;
  logic [3:0]       mnib;
  logic [SizeW-1:0] acc, size_reg, mrem, wcnt, gmark;
  logic [7:0]       offlo;
  logic [15:0]      mdist;
  bit               done;
  beat_t            item_q[$];
  beat_t            decoded_q[$];

  function automatic logic [SizeW-1:0] sat_add(logic [SizeW-1:0] a, longint b);
    longint s;
    s = longint'(a) + b;
    return (s > longint'(SatVal)) ? SatVal : s[SizeW-1:0];
  endfunction

  task push_res(logic kind, logic [7:0] b, logic succ, logic [SizeW-1:0] cnt);
    beat_t r;
    r = '0;
    r.kind = kind;
    r.dbyte = b;
    r.success = succ;
    r.count = cnt;
    item_q.push_back(r);
  endtask

  task emit_fail();
    push_res(KindStatus, 8'h00, 1'b0, gmark);
    done = 1'b1;
  endtask

  task emit_ok();
    push_res(KindStatus, 8'h00, 1'b1, size_reg);
    done = 1'b1;
  endtask

  task put_byte(logic [7:0] b);
    hist[wcnt[15:0]] = b;
    wcnt = wcnt + 1'b1;
    push_res(KindData, b, 1'b0, '0);
  endtask

  task drain_chunk();
    int n;
    logic [15:0] src;
    n = (mrem < ChunkDef) ? int'(mrem) : ChunkDef;
    for (int i = 0; i < n; i++) begin
      src = wcnt[15:0] - mdist;
      put_byte(hist[src]);
    end
    mrem = mrem - 25'(n);
    if (mrem == 0) begin
      gmark = wcnt;
      if (ph == PhMatchEnd) emit_fail();
      else ph = PhToken;
    end
  endtask

  task start_match(logic [SizeW-1:0] len, bit ended);
    if (longint'(wcnt) + longint'(len) > longint'(size_reg)) begin
      emit_fail();
    end else begin
      mrem = len;
      ph = ended ? PhMatchEnd : PhMatch;
      drain_chunk();
    end
  endtask

  task literal_end(bit last);
    if (wcnt == size_reg) emit_ok();
    else if (last) emit_fail();
    else ph = PhOffLo;
  endtask

  task literal_known(bit last);
    if (longint'(wcnt) + longint'(acc) > longint'(size_reg)) emit_fail();
    else if (acc == 0) literal_end(last);
    else if (last) emit_fail();
    else ph = PhLiteral;
  endtask

  task take_byte(logic [7:0] b, bit last);
    case (ph)
      PhToken: begin
        mnib = b[3:0];
        acc = 25'(b[7:4]);
        if (acc == 15) begin
          if (last) emit_fail();
          else ph = PhLitExt;
        end else begin
          literal_known(last);
        end
      end
      PhLitExt: begin
        acc = sat_add(acc, b);
        if (last) emit_fail();
        else if (b != 8'hFF) literal_known(1'b0);
      end
      PhLiteral: begin
        put_byte(b);
        acc = acc - 1'b1;
        if (acc == 0) literal_end(last);
        else if (last) emit_fail();
      end
      PhOffLo: begin
        offlo = b;
        if (last) emit_fail();
        else ph = PhOffHi;
      end
      PhOffHi: begin
        mdist = {b, offlo};
        if (mdist == 0 || 25'(mdist) > wcnt) begin
          emit_fail();
        end else if (mnib == 4'hF) begin
          if (last) emit_fail();
          else begin
            acc = 25'd15;
            ph = PhMatchExt;
          end
        end else begin
          start_match(25'(mnib) + 25'd4, last);
        end
      end
      PhMatchExt: begin
        acc = sat_add(acc, b);
        if (b != 8'hFF || last) start_match(sat_add(acc, 4), last);
      end
      default: ;
    endcase
  endtask

  // Work out every result one accepted input beat causes.
  task decode_beat(logic [1:0] mode, logic [7:0] b, bit last);
    bit draining, refused;
    beat_t r;
    item_q.delete();
    draining = (ph == PhMatch || ph == PhMatchEnd);
    refused = 1'b0;
    if (done || mode == ModeRsvd) return;
    if (mode == ModePull) begin
      if (!draining) return;
      drain_chunk();
    end else if (draining) begin
      refused = 1'b1;
      drain_chunk();
    end else if (size_reg == 0) begin
      emit_ok();
    end else if (mode == ModeEnd) begin
      if (ph == PhToken && wcnt == 0) begin
        push_res(KindStatus, 8'h00, 1'b1, '0);
        done = 1'b1;
      end else begin
        emit_fail();
      end
    end else begin
      take_byte(b, last);
    end
    foreach (item_q[k]) begin
      r = item_q[k];
      if (r.kind == KindData) r.pend = (mrem > 0);
      r.refused = refused;
      r.last = (k == item_q.size() - 1);
      decoded_q.push_back(r);
    end
  endtask

  task cmp(string name, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0h, got %0h", name, e, a);
      errors_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    beat_t got, want;
    if (!rst_ni) begin
      ph = PhToken;
      mnib = '0;
      acc = '0;
      size_reg = '0;
      mrem = '0;
      wcnt = '0;
      gmark = '0;
      offlo = '0;
      mdist = '0;
      done = 1'b0;
      decoded_q.delete();
      errors_o = 0;
      waiting_o = 0;
      data_beats_o = 0;
    end else begin
      // Check the outgoing beat first; it never stems from this edge's input.
      if (m_tvalid_i && m_tready_i) begin
        got.kind    = m_tuser_i;
        got.dbyte   = m_tdata_i[7:0];
        got.pend    = m_tdata_i[8];
        got.refused = m_tdata_i[9];
        got.success = m_tdata_i[10];
        got.count   = m_tdata_i[35:11];
        got.last    = m_tlast_i;
        if (got.kind == KindData) data_beats_o++;
        if (decoded_q.size() == 0) begin
          $error("output beat with nothing expected: %h", got);
          errors_o++;
        end else begin
          want = decoded_q.pop_front();
          cmp("kind", want.kind, got.kind);
          cmp("out_byte", want.dbyte, got.dbyte);
          cmp("match_pending", want.pend, got.pend);
          cmp("refused", want.refused, got.refused);
          cmp("success", want.success, got.success);
          cmp("good_count", want.count, got.count);
          cmp("last_result", want.last, got.last);
          cmp("pad", 0, m_tdata_i[39:36]);
        end
      end
      if (cfg_valid_i && cfg_ready_i)
        size_reg = (cfg_data_i > MaxBlockDef) ? 25'(MaxBlockDef) : cfg_data_i;
      if (s_tvalid_i && s_tready_i) decode_beat(s_tuser_i, s_tdata_i, s_tlast_i);
      waiting_o = decoded_q.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import lz4d_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [SizeW-1:0] cfg_data_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;   // [7:0] data_byte
  logic [1:0]       s_axis_tuser = '0;   // [1:0] mode
  logic             s_axis_tlast = 1'b0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // [7:0] out_byte, [8] match_pending, [9] refused, [10] success,
  // [35:11] good_count, [39:36] zero
  logic [39:0]      m_axis_tdata;
  logic             m_axis_tuser;      // [0] kind
  logic             m_axis_tlast;

  int errors, waiting, data_beats;
  int beats_sent, burst_left, seqs, refusals, noise;
  int unsigned wcnt;   // decoded bytes the stimulus has caused so far
  logic hold = 1'b0;
  int unsigned cyc;

  always #2 clk_i = ~clk_i;

  lz4_block_partial_decoder u_top (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  lz4_scoreboard u_sb (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready), .s_tdata_i(s_axis_tdata),
    .s_tuser_i(s_axis_tuser), .s_tlast_i(s_axis_tlast),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready), .m_tdata_i(m_axis_tdata),
    .m_tuser_i(m_axis_tuser), .m_tlast_i(m_axis_tlast),
    .errors_o(errors), .waiting_o(waiting), .data_beats_o(data_beats)
  );

  // Receiver: alternate spans of random stalls with spans of running flat out.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc <= 0;
      m_axis_tready <= 1'b0;
    end else begin
      cyc <= cyc + 1;
      m_axis_tready <= !hold && (cyc[8] || $urandom_range(0, 9) >= 3);
    end
  end

  // Long hold-off on the output so the command queue fills and tready drops.
  initial begin
    wait (rst_ni);
    repeat (2500) @(posedge clk_i);
    hold <= 1'b1;
    repeat (600) @(posedge clk_i);
    hold <= 1'b0;
  end

  initial begin
    #2000000;
    $display("tb: done, errors");
    $finish;
  end

  // Offer one beat; bursts of random length with random gaps in between.
  task send(logic [1:0] mode, logic [7:0] d, logic last);
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 6)) @(posedge clk_i);
      else @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? 120 : $urandom_range(1, 24);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= mode;
    s_axis_tdata <= d;
    s_axis_tlast <= last;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    burst_left--;
    beats_sent++;
  endtask

  // Write the size register once every expected beat is out and the back end is quiet.
  task write_size(logic [SizeW-1:0] v);
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (waiting != 0);
    repeat (40) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    burst_left = 0;
  endtask

  task send_ext(int unsigned rem);
    while (rem >= 255) begin
      send(ModeByte, 8'hFF, 1'b0);
      rem -= 255;
    end
    send(ModeByte, rem[7:0], 1'b0);
  endtask

  // One sequence: token, literals, then (if mlen > 0 and fin is clear) offset and match with pulls.
  task do_sequence(int unsigned lit, int unsigned mlen, int unsigned dreq, bit fin);
    logic [3:0] hi, lo;
    int unsigned d, lim, pulls, r;
    hi = (lit >= 15) ? 4'hF : lit[3:0];
    lo = (mlen == 0) ? 4'h0 : ((mlen - 4 >= 15) ? 4'hF : 4'(mlen - 4));
    send(ModeByte, {hi, lo}, fin && lit == 0);
    if (lit >= 15) send_ext(lit - 15);
    for (int unsigned i = 0; i < lit; i++)
      send(ModeByte, 8'($urandom), fin && i == lit - 1);
    wcnt += lit;
    seqs++;
    if (fin || mlen == 0) return;
    lim = (wcnt > 65535) ? 65535 : wcnt;
    if (dreq != 0) d = dreq;
    else if ($urandom_range(0, 3) == 0) d = $urandom_range(1, (lim > 16) ? 16 : lim);
    else d = $urandom_range(1, lim);
    send(ModeByte, d[7:0], 1'b0);
    send(ModeByte, d[15:8], 1'b0);
    if (mlen - 4 >= 15) send_ext(mlen - 19);
    wcnt += mlen;
    // Fetch the rest of the match; now and then a source beat stands in for a pull.
    pulls = (mlen + ChunkDef - 1) / ChunkDef - 1;
    for (int unsigned i = 0; i < pulls; i++) begin
      r = $urandom_range(0, 99);
      if (r < 80) send(ModePull, 8'($urandom), 1'($urandom));
      else begin
        send((r < 90) ? ModeByte : ModeEnd, 8'($urandom), 1'($urandom));
        refusals++;
      end
    end
  endtask

  task random_sequence();
    int unsigned r, lit, mlen;
    r = $urandom_range(0, 99);
    lit = (r < 75) ? $urandom_range(0, 14) : (r < 95) ? $urandom_range(15, 60)
        : $urandom_range(255, 300);
    r = $urandom_range(0, 99);
    mlen = (r < 70) ? $urandom_range(4, 18) : (r < 95) ? $urandom_range(19, 90)
         : $urandom_range(280, 640);
    // Ignored beats: stray pulls with no match pending and reserved mode.
    if ($urandom_range(0, 6) == 0) begin
      send($urandom_range(0, 1) ? ModePull : ModeRsvd, 8'($urandom), 1'($urandom));
      noise++;
    end
    do_sequence(lit, mlen, 0, 1'b0);
  endtask

  initial begin
    beats_sent = 0;
    burst_left = 0;
    seqs = 0;
    refusals = 0;
    noise = 0;
    wcnt = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Zero size written and then replaced before any beat; the top value saturates.
    write_size('0);
    write_size('1);

    // Directed: ignored beats, shortest match, exact 15 lengths, long extensions.
    send(ModePull, 8'hFF, 1'b1);
    send(ModeRsvd, 8'hFF, 1'b1);
    send(ModeRsvd, 8'h00, 1'b0);
    do_sequence(1, 4, 1, 1'b0);
    do_sequence(15, 19, 1, 1'b0);
    do_sequence(0, 300, 2, 1'b0);
    do_sequence(270, 5, 0, 1'b0);

    while (beats_sent < 230) random_sequence();
    write_size(25'(MaxBlockDef));
    while (beats_sent < 460) random_sequence();

    // Close the block with a literal run landing exactly on the size.
    write_size(25'(wcnt + 3));
    do_sequence(3, 0, 0, 1'b1);
    s_axis_tvalid <= 1'b0;

    for (int i = 0; i < 200000 && waiting != 0; i++) @(posedge clk_i);
    repeat (100) @(posedge clk_i);

    $display("tb: %0d input beats, %0d sequences, %0d decoded bytes seen", beats_sent,
             seqs, data_beats);
    $display("tb: %0d refused source beats, %0d ignored beats, %0d size writes", refusals,
             noise, 4);
    if (errors == 0 && waiting == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
